// ===== design/rftc_pkg.sv =====
package rftc_pkg;

  // Frame layout
  localparam int unsigned HDR_LEN      = 20;
  localparam int unsigned LIMIT_LEN    = 4096;
  localparam int unsigned ATTR_HDR_LEN = 2;
  localparam int unsigned MIN_ATTR_LEN = 3;

  // Header codes and attribute types of interest
  localparam logic [7:0] CODE_ACCESS_REQUEST = 8'd1;
  localparam logic [7:0] CODE_STATUS_SERVER  = 8'd12;
  localparam logic [7:0] TYPE_MSG_AUTH       = 8'd80;

  // Byte roles
  localparam logic [3:0] ROLE_CODE       = 4'd0;
  localparam logic [3:0] ROLE_ID         = 4'd1;
  localparam logic [3:0] ROLE_LEN_HI     = 4'd2;
  localparam logic [3:0] ROLE_LEN_LO     = 4'd3;
  localparam logic [3:0] ROLE_AUTH       = 4'd4;
  localparam logic [3:0] ROLE_ATTR_TYPE  = 4'd5;
  localparam logic [3:0] ROLE_ATTR_LEN   = 4'd6;
  localparam logic [3:0] ROLE_ATTR_VALUE = 4'd7;
  localparam logic [3:0] ROLE_IGNORED    = 4'd8;

  // Status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_BADAUTH    = 4'd2;
  localparam logic [3:0] ST_TRUNC      = 4'd3;
  localparam logic [3:0] ST_LENSMALL   = 4'd4;
  localparam logic [3:0] ST_LARGE      = 4'd5;
  localparam logic [3:0] ST_TRAILING   = 4'd6;
  localparam logic [3:0] ST_ATTR_TRUNC = 4'd7;
  localparam logic [3:0] ST_ATTR_SMALL = 4'd8;
  localparam logic [3:0] ST_DUP_AUTH   = 4'd9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTH_LOADED = 1'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [7:0]  attr_type;
    logic [15:0] byte_offset;
    logic [7:0]  message_code;
    logic [7:0]  identifier;
    logic [15:0] declared_length;
    logic        auth_check_needed;
    logic [11:0] msg_auth_offset;
    logic [10:0] attr_count;
    logic [3:0]  status;
    logic        done_res;
  } out_word_t;

  typedef struct packed {
    logic [12:0] max_len;
    logic        auth_loaded;
  } cfg_t;

endpackage

// ===== design/radius_frame_tlv_checker_top.sv =====
// RADIUS datagram header and attribute checker.
//
// Input channel: in_valid / in_stall with in_data (data_byte, last_byte), one
// datagram byte per word, last_byte set on the final byte of a datagram.
// Output channel: out_valid / out_stall with out_data, exactly one result word
// per input word: byte role, attribute type, offset, header fields, attribute
// count, Message-Authenticator offset and status (final when done_res is set).
// Configuration: cfg_valid / cfg_ready, cfg_index selects max_message_length
// (0) or request_auth_loaded (1), cfg_data carries the value. Write only while
// no datagram is in flight.
// The result word of a byte is registered: it is offered in the cycle after the
// byte is accepted. Throughput is one byte per cycle while the receiver does not
// stall; it is set by the frame state update and the output register, which loads
// whenever it is empty or its word is taken in the same cycle.
// When the receiver stalls, the output word holds and in_stall rises until
// it is taken. Reset clears the frame state and the output valid flag and sets
// max_message_length to 4096 and request_auth_loaded to 0; in_stall is high
// during reset.
module radius_frame_tlv_checker_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rftc_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rftc_pkg::out_word_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rftc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [12:0]                       cfg_data
);

  rftc_pkg::cfg_t      cfg;
  rftc_pkg::out_word_t res;
  logic                accept;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_len     <= 13'(rftc_pkg::LIMIT_LEN);
      cfg.auth_loaded <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rftc_pkg::CFG_MAX_LEN:     cfg.max_len     <= cfg_data;
        rftc_pkg::CFG_AUTH_LOADED: cfg.auth_loaded <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rftc_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .adv  (accept),
    .word (in_data),
    .cfg  (cfg),
    .res  (res)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted byte produced no result word");

  a_last_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last_byte |=> out_valid && out_data.done_res)
    else $error("last byte result lacks done flag");

  a_short_only_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == rftc_pkg::ST_SHORT |-> out_data.done_res)
    else $error("short buffer status before last byte");

  a_first_byte_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_offset == 16'd0 |-> out_data.byte_role == rftc_pkg::ROLE_CODE)
    else $error("offset zero not tagged as code");

  a_attr_after_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.byte_role == rftc_pkg::ROLE_ATTR_TYPE ||
                  out_data.byte_role == rftc_pkg::ROLE_ATTR_LEN ||
                  out_data.byte_role == rftc_pkg::ROLE_ATTR_VALUE)
      |-> out_data.byte_offset >= 16'(rftc_pkg::HDR_LEN))
    else $error("attribute byte inside header");

endmodule

// ===== design/rftc_parse.sv =====
module rftc_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  rftc_pkg::in_word_t word,
  input  rftc_pkg::cfg_t    cfg,
  output rftc_pkg::out_word_t res
);

  localparam logic [1:0] PH_TYPE  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  logic [15:0] byte_count;
  logic [7:0]  code_reg, code_reg_next;
  logic [7:0]  id_reg, id_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [3:0]  hdr_verdict, hdr_verdict_next;
  logic [1:0]  walk_phase, walk_phase_next;
  logic [12:0] next_attr_start, next_attr_start_next;
  logic [7:0]  cur_type, cur_type_next;
  logic [11:0] auth_attr_pos, auth_attr_pos_next;
  logic [10:0] count_attrs, count_attrs_next;
  logic [3:0]  first_walk_error, first_walk_error_next;

  logic [7:0]  b;
  logic [15:0] off;
  logic [16:0] off_p1;
  logic [16:0] off_p2;
  logic [13:0] attr_end;
  logic [12:0] emax;
  logic [3:0]  role;
  logic [7:0]  atype;
  logic [3:0]  status;
  logic        auth_needed;

  assign b        = word.data_byte;
  assign off      = byte_count;
  assign off_p1   = {1'b0, off} + 17'd1;
  assign off_p2   = {1'b0, off} + 17'(rftc_pkg::ATTR_HDR_LEN);
  assign attr_end = {1'b0, next_attr_start} + {6'd0, b};
  assign emax     = (cfg.max_len > 13'(rftc_pkg::LIMIT_LEN)) ? 13'(rftc_pkg::LIMIT_LEN)
                                                             : cfg.max_len;

  // Header capture, role tagging and attribute walk for one byte
  always_comb begin
    code_reg_next         = code_reg;
    id_reg_next           = id_reg;
    length_reg_next       = length_reg;
    hdr_verdict_next      = hdr_verdict;
    walk_phase_next       = walk_phase;
    next_attr_start_next  = next_attr_start;
    cur_type_next         = cur_type;
    auth_attr_pos_next    = auth_attr_pos;
    count_attrs_next      = count_attrs;
    first_walk_error_next = first_walk_error;
    atype                 = '0;
    role                  = rftc_pkg::ROLE_IGNORED;

    // capture header fields
    if (off == 16'd0) begin
      code_reg_next = b;
    end else if (off == 16'd1) begin
      id_reg_next = b;
    end else if (off == 16'd2) begin
      length_reg_next = {b, 8'd0};
    end else if (off == 16'd3) begin
      length_reg_next = {length_reg[15:8], b};
      if (length_reg_next < 16'(rftc_pkg::HDR_LEN)) begin
        hdr_verdict_next = rftc_pkg::ST_LENSMALL;
      end else if (length_reg_next > {3'd0, emax}) begin
        hdr_verdict_next = rftc_pkg::ST_LARGE;
      end else begin
        hdr_verdict_next = rftc_pkg::ST_OK;
      end
    end

    // tag the byte and advance the walk
    if (off == 16'd0) begin
      role = rftc_pkg::ROLE_CODE;
    end else if (off == 16'd1) begin
      role = rftc_pkg::ROLE_ID;
    end else if (off == 16'd2) begin
      role = rftc_pkg::ROLE_LEN_HI;
    end else if (off == 16'd3) begin
      role = rftc_pkg::ROLE_LEN_LO;
    end else if (off < 16'(rftc_pkg::HDR_LEN)) begin
      role = rftc_pkg::ROLE_AUTH;
    end else if (hdr_verdict_next != rftc_pkg::ST_OK ||
                 first_walk_error != rftc_pkg::ST_OK || off >= length_reg_next) begin
      role = rftc_pkg::ROLE_IGNORED;
    end else begin
      unique case (walk_phase)
        PH_TYPE: begin
          role          = rftc_pkg::ROLE_ATTR_TYPE;
          cur_type_next = b;
          atype         = b;
          if (off_p2 > {1'b0, length_reg_next}) begin
            first_walk_error_next = rftc_pkg::ST_TRAILING;
          end else begin
            walk_phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          role  = rftc_pkg::ROLE_ATTR_LEN;
          atype = cur_type;
          if ({2'd0, attr_end} > length_reg_next) begin
            first_walk_error_next = rftc_pkg::ST_ATTR_TRUNC;
          end else if (b < 8'(rftc_pkg::MIN_ATTR_LEN)) begin
            first_walk_error_next = rftc_pkg::ST_ATTR_SMALL;
          end else if (cur_type == rftc_pkg::TYPE_MSG_AUTH && auth_attr_pos != 12'd0) begin
            first_walk_error_next = rftc_pkg::ST_DUP_AUTH;
          end else begin
            if (cur_type == rftc_pkg::TYPE_MSG_AUTH) begin
              auth_attr_pos_next = next_attr_start[11:0];
            end
            next_attr_start_next = attr_end[12:0];
            walk_phase_next      = PH_VALUE;
          end
        end
        PH_VALUE: begin
          role  = rftc_pkg::ROLE_ATTR_VALUE;
          atype = cur_type;
          if (off_p1 >= {4'd0, next_attr_start}) begin
            if (count_attrs != 11'h7FF) begin
              count_attrs_next = count_attrs + 11'd1;
            end
            walk_phase_next = PH_TYPE;
          end
        end
        default: begin
          role = rftc_pkg::ROLE_IGNORED;
        end
      endcase
    end

    auth_needed = code_reg_next != rftc_pkg::CODE_ACCESS_REQUEST &&
                  code_reg_next != rftc_pkg::CODE_STATUS_SERVER;

    // pick the highest priority status
    if (word.last_byte && off_p1 < 17'(rftc_pkg::HDR_LEN)) begin
      status = rftc_pkg::ST_SHORT;
    end else if (auth_needed && !cfg.auth_loaded) begin
      status = rftc_pkg::ST_BADAUTH;
    end else if (word.last_byte && {1'b0, length_reg_next} > off_p1) begin
      status = rftc_pkg::ST_TRUNC;
    end else if (off >= 16'd3 && hdr_verdict_next != rftc_pkg::ST_OK) begin
      status = hdr_verdict_next;
    end else begin
      status = first_walk_error_next;
    end
  end

  // Assemble the result word
  always_comb begin
    res.byte_role         = role;
    res.attr_type         = atype;
    res.byte_offset       = off;
    res.message_code      = code_reg_next;
    res.identifier        = id_reg_next;
    res.declared_length   = (off >= 16'd3) ? length_reg_next : 16'd0;
    res.auth_check_needed = auth_needed;
    res.msg_auth_offset   = auth_attr_pos_next;
    res.attr_count        = count_attrs_next;
    res.status            = status;
    res.done_res          = word.last_byte;
  end

  // Hold frame state; clear it on reset and after the last byte
  always_ff @(posedge clk) begin
    if (rst || (adv && word.last_byte)) begin
      byte_count       <= '0;
      code_reg         <= '0;
      id_reg           <= '0;
      length_reg       <= '0;
      hdr_verdict      <= rftc_pkg::ST_OK;
      walk_phase       <= PH_TYPE;
      next_attr_start  <= 13'(rftc_pkg::HDR_LEN);
      cur_type         <= '0;
      auth_attr_pos    <= '0;
      count_attrs      <= '0;
      first_walk_error <= rftc_pkg::ST_OK;
    end else if (adv) begin
      if (byte_count != 16'hFFFF) begin
        byte_count <= byte_count + 16'd1;
      end
      code_reg         <= code_reg_next;
      id_reg           <= id_reg_next;
      length_reg       <= length_reg_next;
      hdr_verdict      <= hdr_verdict_next;
      walk_phase       <= walk_phase_next;
      next_attr_start  <= next_attr_start_next;
      cur_type         <= cur_type_next;
      auth_attr_pos    <= auth_attr_pos_next;
      count_attrs      <= count_attrs_next;
      first_walk_error <= first_walk_error_next;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [1:0] {WALK_TYPE, WALK_LEN, WALK_VALUE} walk_phase_e;

  typedef enum {
    FK_GOOD, FK_EXTRA, FK_TRUNC, FK_SHORT, FK_LEN_SMALL, FK_TOO_LARGE,
    FK_TRAILING, FK_ATTR_TRUNC, FK_ATTR_SMALL, FK_DUP_AUTH, FK_NOISE
  } frame_kind_e;

  // Tracks the datagram parse per accepted word and holds the result words still owed
  class frame_walk_board;
    logic [12:0]          max_len;
    logic                 auth_loaded;
    logic [15:0]          byte_count;
    logic [7:0]           code_reg;
    logic [7:0]           id_reg;
    logic [15:0]          length_reg;
    logic [12:0]          next_start;
    logic [7:0]           cur_type;
    logic [11:0]          auth_pos;
    logic [10:0]          count_attrs;
    logic [3:0]           walk_err;
    logic [3:0]           hdr_verdict;
    walk_phase_e          phase;
    rftc_pkg::out_word_t  expected_words[$];
    int                   fail_count;

    function new();
      max_len = 13'(rftc_pkg::LIMIT_LEN);
      auth_loaded = 1'b0;
      fail_count = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count = '0;
      code_reg = '0;
      id_reg = '0;
      length_reg = '0;
      next_start = 13'(rftc_pkg::HDR_LEN);
      cur_type = '0;
      auth_pos = '0;
      count_attrs = '0;
      walk_err = rftc_pkg::ST_OK;
      hdr_verdict = rftc_pkg::ST_OK;
      phase = WALK_TYPE;
    endfunction

    function void set_reg(logic [rftc_pkg::CFG_IDX_W-1:0] idx, logic [12:0] val);
      if (idx == rftc_pkg::CFG_MAX_LEN) max_len = val;
      else auth_loaded = val[0];
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Advance the parse by one accepted word and queue the result it owes
    function void note_byte(rftc_pkg::in_word_t w);
      logic [7:0]          b;
      logic [15:0]         off;
      logic [12:0]         emax;
      logic [12:0]         start;
      logic                auth_needed;
      rftc_pkg::out_word_t r;
      b = w.data_byte;
      off = byte_count;
      r = '0;

      // Capture header fields; latch the length verdict on the low byte
      if (off == 0) code_reg = b;
      else if (off == 1) id_reg = b;
      else if (off == 2) length_reg = {b, 8'h00};
      else if (off == 3) begin
        emax = (max_len > 13'(rftc_pkg::LIMIT_LEN)) ? 13'(rftc_pkg::LIMIT_LEN) : max_len;
        length_reg[7:0] = b;
        if (32'(length_reg) < rftc_pkg::HDR_LEN) hdr_verdict = rftc_pkg::ST_LENSMALL;
        else if (length_reg > 16'(emax)) hdr_verdict = rftc_pkg::ST_LARGE;
        else hdr_verdict = rftc_pkg::ST_OK;
      end

      // Tag the word and walk the attribute records
      if (off < 4) begin
        case (off[1:0])
          2'd0: r.byte_role = rftc_pkg::ROLE_CODE;
          2'd1: r.byte_role = rftc_pkg::ROLE_ID;
          2'd2: r.byte_role = rftc_pkg::ROLE_LEN_HI;
          default: r.byte_role = rftc_pkg::ROLE_LEN_LO;
        endcase
      end else if (32'(off) < rftc_pkg::HDR_LEN) begin
        r.byte_role = rftc_pkg::ROLE_AUTH;
      end else if (hdr_verdict != rftc_pkg::ST_OK || walk_err != rftc_pkg::ST_OK ||
                   off >= length_reg) begin
        r.byte_role = rftc_pkg::ROLE_IGNORED;
      end else begin
        case (phase)
          WALK_TYPE: begin
            r.byte_role = rftc_pkg::ROLE_ATTR_TYPE;
            cur_type = b;
            r.attr_type = b;
            if (32'(off) + rftc_pkg::ATTR_HDR_LEN > 32'(length_reg))
              walk_err = rftc_pkg::ST_TRAILING;
            else phase = WALK_LEN;
          end
          WALK_LEN: begin
            start = next_start;
            r.byte_role = rftc_pkg::ROLE_ATTR_LEN;
            r.attr_type = cur_type;
            if (32'(start) + 32'(b) > 32'(length_reg)) begin
              walk_err = rftc_pkg::ST_ATTR_TRUNC;
            end else if (32'(b) < rftc_pkg::MIN_ATTR_LEN) begin
              walk_err = rftc_pkg::ST_ATTR_SMALL;
            end else if (cur_type == rftc_pkg::TYPE_MSG_AUTH && auth_pos != 0) begin
              walk_err = rftc_pkg::ST_DUP_AUTH;
            end else begin
              if (cur_type == rftc_pkg::TYPE_MSG_AUTH) auth_pos = start[11:0];
              next_start = 13'(32'(start) + 32'(b));
              phase = WALK_VALUE;
            end
          end
          default: begin
            r.byte_role = rftc_pkg::ROLE_ATTR_VALUE;
            r.attr_type = cur_type;
            if (32'(off) + 1 >= 32'(next_start)) begin
              if (count_attrs != 11'h7FF) count_attrs++;
              phase = WALK_TYPE;
            end
          end
        endcase
      end

      auth_needed = code_reg != rftc_pkg::CODE_ACCESS_REQUEST &&
                    code_reg != rftc_pkg::CODE_STATUS_SERVER;

      // Pick the status by priority; only the last word carries the final one
      if (w.last_byte && 32'(off) + 1 < rftc_pkg::HDR_LEN) r.status = rftc_pkg::ST_SHORT;
      else if (auth_needed && !auth_loaded) r.status = rftc_pkg::ST_BADAUTH;
      else if (w.last_byte && 32'(length_reg) > 32'(off) + 1) r.status = rftc_pkg::ST_TRUNC;
      else if (off >= 3 && hdr_verdict != rftc_pkg::ST_OK) r.status = hdr_verdict;
      else r.status = walk_err;

      r.byte_offset = off;
      r.message_code = code_reg;
      r.identifier = id_reg;
      r.declared_length = (off >= 3) ? length_reg : 16'h0000;
      r.auth_check_needed = auth_needed;
      r.msg_auth_offset = auth_pos;
      r.attr_count = count_attrs;
      r.done_res = w.last_byte;
      expected_words.push_back(r);

      if (w.last_byte) clear_frame();
      else if (byte_count != 16'hFFFF) byte_count++;
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        fail_count++;
      end
    endfunction

    // Compare one taken result word against the oldest one owed
    function void check_word(rftc_pkg::out_word_t got);
      rftc_pkg::out_word_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected, expected none actual %h",
                 $time, got);
        fail_count++;
        return;
      end
      exp_w = expected_words.pop_front();
      check_field("byte_role", exp_w.byte_role, got.byte_role);
      check_field("attr_type", exp_w.attr_type, got.attr_type);
      check_field("byte_offset", exp_w.byte_offset, got.byte_offset);
      check_field("message_code", exp_w.message_code, got.message_code);
      check_field("identifier", exp_w.identifier, got.identifier);
      check_field("declared_length", exp_w.declared_length, got.declared_length);
      check_field("auth_check_needed", exp_w.auth_check_needed, got.auth_check_needed);
      check_field("msg_auth_offset", exp_w.msg_auth_offset, got.msg_auth_offset);
      check_field("attr_count", exp_w.attr_count, got.attr_count);
      check_field("status", exp_w.status, got.status);
      check_field("done_res", exp_w.done_res, got.done_res);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  rftc_pkg::in_word_t             in_data;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  rftc_pkg::out_word_t            out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rftc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [12:0]                    cfg_data;

  frame_walk_board board = new();
  logic [7:0]      frame_q[$];
  int              cur_max = rftc_pkg::LIMIT_LEN;
  int              bytes_sent = 0;
  int              stall_left = 0;
  bit              took_word = 1'b0;
  bit              quiet = 1'b0;

  radius_frame_tlv_checker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function int draw_wait();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_byte(in_data);
  end

  always @(posedge clk) begin
    took_word = !rst && out_valid && !out_stall;
    if (took_word) board.check_word(out_data);
  end

  // After each taken word, stall the output channel while the drawn wait runs down
  always @(negedge clk) begin
    if (took_word) stall_left = draw_wait();
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input rftc_pkg::in_word_t w);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold the sender until every owed result word has been taken
  task automatic drain();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rftc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [12:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    if (idx == rftc_pkg::CFG_MAX_LEN)
      cur_max = (val > rftc_pkg::LIMIT_LEN) ? rftc_pkg::LIMIT_LEN : val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic push_attr(input logic [7:0] t, input int len);
    frame_q.push_back(t);
    frame_q.push_back(8'(len));
    repeat (len - 2) frame_q.push_back(8'($urandom));
  endtask

  task automatic prepend_header(input logic [7:0] code, input logic [15:0] decl);
    logic [7:0] hdr_bytes [20];
    int i;
    hdr_bytes[0] = code;
    hdr_bytes[1] = 8'($urandom);
    hdr_bytes[2] = decl[15:8];
    hdr_bytes[3] = decl[7:0];
    for (i = 4; i < 20; i++) hdr_bytes[i] = 8'($urandom);
    for (i = 19; i >= 0; i--) frame_q.push_front(hdr_bytes[i]);
  endtask

  function logic [7:0] pick_code();
    case ($urandom_range(0, 3))
      0: return rftc_pkg::CODE_ACCESS_REQUEST;
      1: return rftc_pkg::CODE_STATUS_SERVER;
      default: return 8'($urandom);
    endcase
  endfunction

  // Build one datagram of the given shape into frame_q
  task automatic build_frame(input frame_kind_e kind, input logic [7:0] code);
    int         n;
    int         len;
    int         decl;
    logic [7:0] t;
    bit         have_auth;
    frame_q.delete();
    have_auth = 1'b0;
    if (kind == FK_NOISE) begin
      n = $urandom_range(1, 60);
      repeat (n) frame_q.push_back(8'($urandom));
      return;
    end

    // Well-formed records first, at most one authenticator among them
    n = $urandom_range(0, 4);
    repeat (n) begin
      t = ($urandom_range(0, 5) == 0) ? rftc_pkg::TYPE_MSG_AUTH : 8'($urandom);
      if (t == rftc_pkg::TYPE_MSG_AUTH && have_auth) t = 8'd26;
      if (t == rftc_pkg::TYPE_MSG_AUTH) have_auth = 1'b1;
      push_attr(t, $urandom_range(3, 12));
    end

    // Then the broken tail, if any
    case (kind)
      FK_TRAILING: frame_q.push_back(8'($urandom));
      FK_ATTR_TRUNC: begin
        len = $urandom_range(3, 40);
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'(len));
        repeat ($urandom_range(0, len - 3)) frame_q.push_back(8'($urandom));
      end
      FK_ATTR_SMALL: begin
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'($urandom_range(0, 2)));
        repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
      end
      FK_DUP_AUTH: begin
        push_attr(rftc_pkg::TYPE_MSG_AUTH, 18);
        push_attr(rftc_pkg::TYPE_MSG_AUTH, $urandom_range(3, 18));
      end
      default: ;
    endcase

    decl = rftc_pkg::HDR_LEN + frame_q.size();
    case (kind)
      FK_TRUNC: decl += $urandom_range(1, 8);
      FK_LEN_SMALL: decl = $urandom_range(0, 19);
      FK_TOO_LARGE: decl = ($urandom_range(0, 3) == 0) ? 65535
                           : cur_max + $urandom_range(1, 300);
      default: ;
    endcase
    prepend_header(code, 16'(decl));

    if (kind == FK_EXTRA)
      repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
    if (kind == FK_SHORT) begin
      n = $urandom_range(1, 19);
      while (frame_q.size() > n) frame_q.delete(frame_q.size() - 1);
    end
  endtask

  task automatic send_frame();
    rftc_pkg::in_word_t w;
    int                 i;
    for (i = 0; i < frame_q.size(); i++) begin
      w.data_byte = frame_q[i];
      w.last_byte = (i == frame_q.size() - 1);
      // Pause now and then until the block has caught up
      if (!quiet && $urandom_range(0, 49) == 0) drain();
      send_byte(w);
      bytes_sent++;
    end
  endtask

  task automatic run_frame(input frame_kind_e kind, input logic [7:0] code);
    build_frame(kind, code);
    send_frame();
  endtask

  // Header only, with a given declared length and no records
  task automatic run_bare(input logic [7:0] code, input logic [15:0] decl);
    frame_q.delete();
    prepend_header(code, decl);
    send_frame();
  endtask

  // Give up on a hung run
  initial begin
    #20_000_000;
    $display("radius_frame_tlv_checker_top: mismatch");
    $finish;
  end

  initial begin
    int          frames;
    int          pick;
    logic [12:0] max_val;
    frame_kind_e kind;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = rftc_pkg::CFG_MAX_LEN;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: header codes against the authenticator flag
    frame_q.delete();
    push_attr(rftc_pkg::TYPE_MSG_AUTH, 18);
    push_attr(8'd1, 5);
    prepend_header(rftc_pkg::CODE_ACCESS_REQUEST, 16'(rftc_pkg::HDR_LEN + frame_q.size()));
    send_frame();
    frame_q.delete();
    frame_q.push_back(rftc_pkg::CODE_ACCESS_REQUEST);
    send_frame();
    run_frame(FK_GOOD, 8'd2);
    drain();
    write_reg(rftc_pkg::CFG_AUTH_LOADED, 13'd1);
    run_frame(FK_GOOD, 8'd2);
    run_frame(FK_GOOD, rftc_pkg::CODE_STATUS_SERVER);
    run_frame(FK_GOOD, 8'd255);

    // Directed: each broken shape
    run_frame(FK_EXTRA, rftc_pkg::CODE_ACCESS_REQUEST);
    run_frame(FK_TRUNC, rftc_pkg::CODE_ACCESS_REQUEST);
    run_frame(FK_SHORT, rftc_pkg::CODE_ACCESS_REQUEST);
    run_frame(FK_LEN_SMALL, rftc_pkg::CODE_ACCESS_REQUEST);
    run_bare(rftc_pkg::CODE_ACCESS_REQUEST, 16'h0000);
    run_bare(rftc_pkg::CODE_ACCESS_REQUEST, 16'hFFFF);
    run_frame(FK_TOO_LARGE, rftc_pkg::CODE_ACCESS_REQUEST);
    run_frame(FK_TRAILING, rftc_pkg::CODE_ACCESS_REQUEST);
    run_frame(FK_ATTR_TRUNC, rftc_pkg::CODE_ACCESS_REQUEST);
    repeat (3) run_frame(FK_ATTR_SMALL, rftc_pkg::CODE_ACCESS_REQUEST);
    run_frame(FK_DUP_AUTH, rftc_pkg::CODE_ACCESS_REQUEST);
    run_frame(FK_NOISE, 8'd0);

    // Directed: length limit at its extremes
    drain();
    write_reg(rftc_pkg::CFG_MAX_LEN, 13'd20);
    run_bare(rftc_pkg::CODE_ACCESS_REQUEST, 16'd20);
    run_bare(rftc_pkg::CODE_ACCESS_REQUEST, 16'd21);
    drain();
    write_reg(rftc_pkg::CFG_MAX_LEN, 13'h1FFF);
    run_bare(rftc_pkg::CODE_ACCESS_REQUEST, 16'd4097);
    drain();
    write_reg(rftc_pkg::CFG_MAX_LEN, 13'd0);
    run_bare(rftc_pkg::CODE_ACCESS_REQUEST, 16'd20);
    drain();
    write_reg(rftc_pkg::CFG_MAX_LEN, 13'(rftc_pkg::LIMIT_LEN));

    // Random: mostly well-formed datagrams, settings changed between phases
    frames = 0;
    while (bytes_sent < 1050) begin
      if (frames % 6 == 0) begin
        drain();
        pick = $urandom_range(0, 5);
        if (pick <= 2) max_val = 13'(rftc_pkg::LIMIT_LEN);
        else if (pick == 3) max_val = 13'($urandom_range(20, 120));
        else if (pick == 4) max_val = ($urandom_range(0, 1) == 0) ? 13'h1FFF : 13'd20;
        else max_val = 13'($urandom_range(121, 4095));
        write_reg(rftc_pkg::CFG_MAX_LEN, max_val);
        write_reg(rftc_pkg::CFG_AUTH_LOADED, 13'($urandom_range(0, 3) != 0));
      end
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 5)
        kind = ($urandom_range(0, 2) == 0) ? FK_EXTRA : FK_GOOD;
      else
        kind = frame_kind_e'($urandom_range(2, 10));
      run_frame(kind, pick_code());
      frames++;
    end
    quiet = 1'b0;

    // Let the last results out, then report
    drain();
    repeat (4) @(negedge clk);
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("radius_frame_tlv_checker_top: match");
    end else begin
      $display("radius_frame_tlv_checker_top: mismatch");
    end
    $finish;
  end

endmodule
